/* src/ddo_pkg.sv */
// Shared types and constants of the differential-drive odometry block.
`default_nettype none

package ddo_pkg;

    localparam int FRAC_W  = 30;
    localparam int TERM_W  = 31;
    localparam int X_W     = 30;
    localparam int ACC_W   = 32;
    localparam int PI_SH   = 31;
    localparam int N_TERMS = 9;

    localparam logic [TERM_W-1:0] ONE_Q30 = 31'h4000_0000;
    localparam logic [31:0]       PI_Q30  = 32'hC90F_DAA2;

    typedef struct packed {
        logic                    valid;
        logic [TERM_W-1:0]       p_term;
        logic [TERM_W-1:0]       q_term;
        logic signed [ACC_W-1:0] p_acc;
        logic signed [ACC_W-1:0] q_acc;
        logic [X_W-1:0]          x_sq;
    } t_link;

    typedef enum logic [2:0] {
        REG_DEAD_ZONE,
        REG_MM_PER_TICK,
        REG_TURN_PER_TICK,
        REG_START_X,
        REG_START_Y,
        REG_START_HEADING
    } t_reg_idx;

    typedef enum logic [2:0] {
        S_IDLE,
        S_HEAD,
        S_LAUNCH,
        S_TRIG,
        S_MUL,
        S_POS
    } t_state;

endpackage

`default_nettype wire

/* src/ddo_cell.sv */
// One Taylor-series cell: next term by multiply and constant division, then accumulate.
`default_nettype none

module ddo_cell #(
    parameter int DIV = 2,
    parameter bit SUB = 1'b1
) (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  ddo_pkg::t_link      i_link,
    output ddo_pkg::t_link      o_link
);
    import ddo_pkg::*;

    localparam logic [X_W-1:0] RECIP = X_W'((64'd1 << FRAC_W) / DIV);

    logic [TERM_W+X_W-1:0]   w_prod;
    logic [TERM_W+X_W-1:0]   w_qm;
    logic [TERM_W-1:0]       w_dq;
    logic [TERM_W-1:0]       w_rem;
    logic [TERM_W-1:0]       w_quot;
    logic signed [ACC_W-1:0] w_term_s;

    logic                    r_a_valid;
    logic [TERM_W-1:0]       r_a_prod;
    logic [TERM_W-1:0]       r_a_q_term;
    logic signed [ACC_W-1:0] r_a_p_acc;
    logic signed [ACC_W-1:0] r_a_q_acc;
    logic [X_W-1:0]          r_a_x_sq;

    logic                    r_b_valid;
    logic [TERM_W-1:0]       r_b_prod;
    logic [TERM_W-1:0]       r_b_quot;
    logic [TERM_W-1:0]       r_b_q_term;
    logic signed [ACC_W-1:0] r_b_p_acc;
    logic signed [ACC_W-1:0] r_b_q_acc;
    logic [X_W-1:0]          r_b_x_sq;

    logic                    r_c_valid;
    logic [TERM_W-1:0]       r_c_p_term;
    logic [TERM_W-1:0]       r_c_q_term;
    logic signed [ACC_W-1:0] r_c_p_acc;
    logic signed [ACC_W-1:0] r_c_q_acc;
    logic [X_W-1:0]          r_c_x_sq;

    assign w_prod   = i_link.p_term * i_link.x_sq;
    assign w_qm     = r_a_prod * RECIP;
    assign w_dq     = r_b_quot * TERM_W'(DIV);
    assign w_rem    = r_b_prod - w_dq;
    assign w_quot   = (w_rem >= TERM_W'(DIV)) ? r_b_quot + 1'b1 : r_b_quot;
    assign w_term_s = $signed({1'b0, w_quot});

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_valid <= 1'b0;
            r_b_valid <= 1'b0;
            r_c_valid <= 1'b0;
        end else begin
            r_a_valid <= i_link.valid;
            r_b_valid <= r_a_valid;
            r_c_valid <= r_b_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_a_prod   <= w_prod[TERM_W+X_W-1:FRAC_W];
        r_a_q_term <= i_link.q_term;
        r_a_p_acc  <= i_link.p_acc;
        r_a_q_acc  <= i_link.q_acc;
        r_a_x_sq   <= i_link.x_sq;

        r_b_prod   <= r_a_prod;
        r_b_quot   <= w_qm[TERM_W+X_W-1:FRAC_W];
        r_b_q_term <= r_a_q_term;
        r_b_p_acc  <= r_a_p_acc;
        r_b_q_acc  <= r_a_q_acc;
        r_b_x_sq   <= r_a_x_sq;

        r_c_p_term <= r_b_q_term;
        r_c_q_term <= w_quot;
        r_c_p_acc  <= r_b_q_acc;
        r_c_q_acc  <= SUB ? r_b_p_acc - w_term_s : r_b_p_acc + w_term_s;
        r_c_x_sq   <= r_b_x_sq;
    end

    assign o_link = '{valid:  r_c_valid,
                      p_term: r_c_p_term,
                      q_term: r_c_q_term,
                      p_acc:  r_c_p_acc,
                      q_acc:  r_c_q_acc,
                      x_sq:   r_c_x_sq};

endmodule

`default_nettype wire

/* src/ddo_trig.sv */
// Heading to cosine and sine: octant fold, chain of Taylor cells, quadrant map and rounding.
`default_nettype none

module ddo_trig #(
    parameter int TRIG_BITS = 16
) (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  i_start,
    input  wire logic [31:0]           i_heading,
    output logic                       o_done,
    output logic signed [TRIG_BITS:0]  o_cos,
    output logic signed [TRIG_BITS:0]  o_sin
);
    import ddo_pkg::*;

    localparam int RND_SH = ACC_W - 1 - TRIG_BITS;
    localparam logic [ACC_W-1:0] RND_HALF = ACC_W'(1) << (RND_SH - 1);
    localparam logic [X_W:0] QUARTER_TURN = (X_W + 1)'(1) << 30;

    logic [29:0]             w_frac;
    logic                    w_swap;
    logic [X_W:0]            w_oct;
    logic [X_W+PI_SH:0]      w_xprod;
    logic [2*X_W-1:0]        w_x2prod;
    logic signed [ACC_W-1:0] w_s0;
    logic signed [ACC_W-1:0] w_c0;
    logic [ACC_W-1:0]        w_s0_sum;
    logic [ACC_W-1:0]        w_c0_sum;
    logic signed [TRIG_BITS:0] w_sp;
    logic signed [TRIG_BITS:0] w_cp;
    logic signed [TRIG_BITS:0] w_cos;
    logic signed [TRIG_BITS:0] w_sin;

    logic            r_v1;
    logic            r_v2;
    logic [X_W-1:0]  r_x;
    logic [X_W-1:0]  r_xs;
    logic [X_W-1:0]  r_x2;
    logic [1:0]      r_quad;
    logic            r_swap;

    t_link w_link [N_TERMS+1];

    assign w_frac   = i_heading[29:0];
    assign w_swap   = w_frac[29];
    assign w_oct    = w_swap ? QUARTER_TURN - {1'b0, w_frac} : {1'b0, w_frac};
    assign w_xprod  = w_oct[X_W-1:0] * PI_Q30;
    assign w_x2prod = r_x * r_x;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1   <= 1'b0;
            r_v2   <= 1'b0;
            o_done <= 1'b0;
        end else begin
            r_v1   <= i_start;
            r_v2   <= r_v1;
            o_done <= w_link[N_TERMS].valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_x    <= w_xprod[X_W+PI_SH-1:PI_SH];
            r_quad <= i_heading[31:30];
            r_swap <= w_swap;
        end
        r_x2 <= w_x2prod[2*X_W-1:FRAC_W];
        r_xs <= r_x;
        if (w_link[N_TERMS].valid) begin
            o_cos <= w_cos;
            o_sin <= w_sin;
        end
    end

    // The cosine series starts at one and the sine series at x; each cell adds one term.
    assign w_link[0] = '{valid:  r_v2,
                         p_term: ONE_Q30,
                         q_term: {1'b0, r_xs},
                         p_acc:  $signed(ACC_W'(ONE_Q30)),
                         q_acc:  $signed({2'b00, r_xs}),
                         x_sq:   r_x2};

    for (genvar k = 0; k < N_TERMS; k++) begin : g_cell
        ddo_cell #(
            .DIV ((k + 1) * (k + 2)),
            .SUB (((k + 2) / 2) % 2 == 1)
        ) u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_link  (w_link[k]),
            .o_link  (w_link[k+1])
        );
    end

    // After an odd number of cells the sine sum sits in p_acc and the cosine sum in q_acc.
    assign w_s0 = r_swap ? w_link[N_TERMS].q_acc : w_link[N_TERMS].p_acc;
    assign w_c0 = r_swap ? w_link[N_TERMS].p_acc : w_link[N_TERMS].q_acc;

    assign w_s0_sum = {1'b0, w_s0[TERM_W-1:0]} + RND_HALF;
    assign w_c0_sum = {1'b0, w_c0[TERM_W-1:0]} + RND_HALF;
    assign w_sp     = $signed({1'b0, w_s0_sum[RND_SH +: TRIG_BITS]});
    assign w_cp     = $signed({1'b0, w_c0_sum[RND_SH +: TRIG_BITS]});

    always_comb begin
        case (r_quad)
            2'd0: begin
                w_cos = w_cp;
                w_sin = w_sp;
            end
            2'd1: begin
                w_cos = -w_sp;
                w_sin = w_cp;
            end
            2'd2: begin
                w_cos = -w_cp;
                w_sin = -w_sp;
            end
            default: begin
                w_cos = w_sp;
                w_sin = -w_cp;
            end
        endcase
    end

endmodule

`default_nettype wire

/* src/diff_drive_odometry.sv */
// Top level of the differential-drive odometry block: registers, sequencer and pose update.
`default_nettype none

// Dead-reckoning pose tracker. Each request on the input stream carries signed left and
// right tick counts; the block answers with one request holding the new X, Y (1/256 mm,
// saturating) and heading (2^-32 turns, wrapping). A result is produced once the chain of
// nine Taylor cells of three stages each has evaluated sine and cosine, and no new request
// is taken while one is in flight; the input is taken again as soon as the result is in
// the output register, and waits only while an earlier result has not been taken. Writing
// any start-pose register loads the start pose into the state at once; there is no
// clearing pass.
module diff_drive_odometry #(
    parameter int TRIG_BITS = 16
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_s_axis_tvalid,
    output logic             o_s_axis_tready,
    input  wire logic [31:0] i_s_axis_tdata,   // [15:0] left_ticks, [31:16] right_ticks
    output logic             o_m_axis_tvalid,
    input  wire logic        i_m_axis_tready,
    output logic [95:0]      o_m_axis_tdata,   // [31:0] pos_x, [63:32] pos_y, [95:64] heading
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [4:0]  paddr,
    input  wire logic [31:0] pwdata,
    output logic [31:0]      prdata,
    output logic             pready
);
    import ddo_pkg::*;

    localparam int D_W    = 36;
    localparam int PROD_W = D_W + TRIG_BITS + 1;
    localparam int INC_SH = TRIG_BITS + 8;
    localparam int INC_W  = PROD_W + 1 - INC_SH;
    localparam int SUM_W  = 34;
    localparam logic [PROD_W:0] INC_HALF = (PROD_W + 1)'(1) << (INC_SH - 1);

    localparam logic [9:0]  DEAD_ZONE_RST = 10'd10;
    localparam logic [17:0] MM_RST        = 18'd18096;
    localparam logic [23:0] TURN_RST      = 24'd693900;

    function automatic logic signed [INC_W:0] round_inc(input logic signed [PROD_W-1:0] v);
        logic [PROD_W-1:0] mag;
        logic [PROD_W:0]   rnd;
        logic [INC_W-1:0]  q;
        mag = v[PROD_W-1] ? PROD_W'(-v) : PROD_W'(v);
        rnd = {1'b0, mag} + INC_HALF;
        q   = rnd[PROD_W:INC_SH];
        round_inc = v[PROD_W-1] ? -$signed({1'b0, q}) : $signed({1'b0, q});
    endfunction

    function automatic logic [31:0] sat_add(input logic signed [31:0] pos,
                                            input logic signed [INC_W:0] inc);
        logic signed [SUM_W-1:0] s;
        s = SUM_W'(pos) + SUM_W'(inc);
        if (s[SUM_W-1:31] == {(SUM_W - 31){s[SUM_W-1]}}) begin
            sat_add = s[31:0];
        end else begin
            sat_add = s[SUM_W-1] ? 32'h8000_0000 : 32'h7FFF_FFFF;
        end
    endfunction

    t_state r_state;
    t_state n_state;

    logic [9:0]  r_dead_zone;
    logic [17:0] r_mm_per_tick;
    logic [23:0] r_turn_per_tick;
    logic [31:0] r_start_x;
    logic [31:0] r_start_y;
    logic [31:0] r_start_heading;
    logic [31:0] n_start_x;
    logic [31:0] n_start_y;
    logic [31:0] n_start_heading;

    logic signed [31:0] r_x_pos;
    logic signed [31:0] r_y_pos;
    logic [31:0]        r_heading;
    logic [31:0]        n_heading;

    logic signed [15:0]       r_left;
    logic signed [15:0]       r_right;
    logic signed [D_W-1:0]    r_d;
    logic signed [PROD_W-1:0] r_prod_x;
    logic signed [PROD_W-1:0] r_prod_y;

    logic        r_out_valid;
    logic [31:0] r_out_x;
    logic [31:0] r_out_y;
    logic [31:0] r_out_heading;

    logic        w_cfg_wr;
    t_reg_idx    w_cfg_idx;
    logic        w_load_start;
    logic        w_accept;
    logic        w_trig_start;
    logic        w_trig_done;
    logic        w_pos_load;

    logic signed [15:0]        w_left;
    logic signed [15:0]        w_right;
    logic signed [16:0]        w_left_x;
    logic signed [16:0]        w_right_x;
    logic [16:0]               w_left_mag;
    logic [16:0]               w_right_mag;
    logic signed [16:0]        w_diff;
    logic signed [16:0]        w_sum;
    logic signed [41:0]        w_turn;
    logic signed [D_W-1:0]     w_d;
    logic signed [TRIG_BITS:0] w_cos;
    logic signed [TRIG_BITS:0] w_sin;
    logic signed [PROD_W-1:0]  w_prod_x;
    logic signed [PROD_W-1:0]  w_prod_y;
    logic [31:0]               w_new_x;
    logic [31:0]               w_new_y;

    // Configuration port.
    assign pready    = 1'b1;
    assign w_cfg_wr  = psel & penable & pwrite;
    assign w_cfg_idx = t_reg_idx'(paddr[4:2]);

    always_comb begin
        n_start_x       = r_start_x;
        n_start_y       = r_start_y;
        n_start_heading = r_start_heading;
        w_load_start    = 1'b0;
        if (w_cfg_wr) begin
            unique case (w_cfg_idx)
                REG_START_X: begin
                    n_start_x    = pwdata;
                    w_load_start = 1'b1;
                end
                REG_START_Y: begin
                    n_start_y    = pwdata;
                    w_load_start = 1'b1;
                end
                REG_START_HEADING: begin
                    n_start_heading = pwdata;
                    w_load_start    = 1'b1;
                end
                default: begin
                    w_load_start = 1'b0;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_dead_zone     <= DEAD_ZONE_RST;
            r_mm_per_tick   <= MM_RST;
            r_turn_per_tick <= TURN_RST;
            r_start_x       <= '0;
            r_start_y       <= '0;
            r_start_heading <= '0;
        end else begin
            r_start_x       <= n_start_x;
            r_start_y       <= n_start_y;
            r_start_heading <= n_start_heading;
            if (w_cfg_wr) begin
                unique case (w_cfg_idx)
                    REG_DEAD_ZONE:     r_dead_zone     <= pwdata[9:0];
                    REG_MM_PER_TICK:   r_mm_per_tick   <= pwdata[17:0];
                    REG_TURN_PER_TICK: r_turn_per_tick <= pwdata[23:0];
                    default: begin
                    end
                endcase
            end
        end
    end

    always_comb begin
        unique case (w_cfg_idx)
            REG_DEAD_ZONE:     prdata = 32'(r_dead_zone);
            REG_MM_PER_TICK:   prdata = 32'(r_mm_per_tick);
            REG_TURN_PER_TICK: prdata = 32'(r_turn_per_tick);
            REG_START_X:       prdata = r_start_x;
            REG_START_Y:       prdata = r_start_y;
            REG_START_HEADING: prdata = r_start_heading;
            default:           prdata = 32'd0;
        endcase
    end

    // Sequencer.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state         = r_state;
        o_s_axis_tready = 1'b0;
        w_trig_start    = 1'b0;
        w_pos_load      = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                o_s_axis_tready = 1'b1;
                if (i_s_axis_tvalid) begin
                    n_state = S_HEAD;
                end
            end
            S_HEAD: begin
                n_state = S_LAUNCH;
            end
            S_LAUNCH: begin
                w_trig_start = 1'b1;
                n_state      = S_TRIG;
            end
            S_TRIG: begin
                if (w_trig_done) begin
                    n_state = S_MUL;
                end
            end
            S_MUL: begin
                n_state = S_POS;
            end
            S_POS: begin
                if (!r_out_valid || i_m_axis_tready) begin
                    w_pos_load = 1'b1;
                    n_state    = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    assign w_accept = i_s_axis_tvalid & o_s_axis_tready;

    // Dead zone on the incoming counts.
    assign w_left      = $signed(i_s_axis_tdata[15:0]);
    assign w_right     = $signed(i_s_axis_tdata[31:16]);
    assign w_left_x    = 17'(w_left);
    assign w_right_x   = 17'(w_right);
    assign w_left_mag  = w_left_x[16] ? 17'(-w_left_x) : 17'(w_left_x);
    assign w_right_mag = w_right_x[16] ? 17'(-w_right_x) : 17'(w_right_x);

    // Heading step and travel.
    assign w_diff    = 17'(r_right) - 17'(r_left);
    assign w_sum     = 17'(r_right) + 17'(r_left);
    assign w_turn    = $signed({1'b0, r_turn_per_tick}) * w_diff;
    assign w_d       = $signed({1'b0, r_mm_per_tick}) * w_sum;
    assign n_heading = r_heading + w_turn[31:0];

    ddo_trig #(
        .TRIG_BITS (TRIG_BITS)
    ) u_trig (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_start   (w_trig_start),
        .i_heading (r_heading),
        .o_done    (w_trig_done),
        .o_cos     (w_cos),
        .o_sin     (w_sin)
    );

    assign w_prod_x = r_d * w_cos;
    assign w_prod_y = r_d * w_sin;
    assign w_new_x  = sat_add(r_x_pos, round_inc(r_prod_x));
    assign w_new_y  = sat_add(r_y_pos, round_inc(r_prod_y));

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_left  <= (w_left_mag < 17'(r_dead_zone)) ? 16'sd0 : w_left;
            r_right <= (w_right_mag < 17'(r_dead_zone)) ? 16'sd0 : w_right;
        end
        if (r_state == S_HEAD) begin
            r_d <= w_d;
        end
        if (r_state == S_MUL) begin
            r_prod_x <= w_prod_x;
            r_prod_y <= w_prod_y;
        end
        if (w_pos_load) begin
            r_out_x       <= w_new_x;
            r_out_y       <= w_new_y;
            r_out_heading <= r_heading;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_x_pos   <= '0;
            r_y_pos   <= '0;
            r_heading <= '0;
        end else if (w_load_start) begin
            r_x_pos   <= $signed(n_start_x);
            r_y_pos   <= $signed(n_start_y);
            r_heading <= n_start_heading;
        end else begin
            if (r_state == S_HEAD) begin
                r_heading <= n_heading;
            end
            if (w_pos_load) begin
                r_x_pos <= $signed(w_new_x);
                r_y_pos <= $signed(w_new_y);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_pos_load) begin
            r_out_valid <= 1'b1;
        end else if (i_m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = {r_out_heading, r_out_y, r_out_x};

    a_trig_done_when_waiting: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_trig_done |-> (r_state == S_TRIG))
        else $error("Trig result arrived while the sequencer was not waiting for it.");

    a_accept_starts_item: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_s_axis_tvalid && o_s_axis_tready) |=> (r_state == S_HEAD))
        else $error("Accepted request did not start the heading update.");

    a_pose_holds_when_blocked: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_POS && r_out_valid && !i_m_axis_tready && !w_cfg_wr)
        |=> ($stable(r_x_pos) && $stable(r_y_pos)))
        else $error("Position changed while the result was blocked.");

endmodule

`default_nettype wire

/* verif/ddo_pose_checker.sv */
// Pose checker for the odometry block: predicts each pose from the tick requests and compares.
`timescale 1ns / 1ps

module ddo_pose_checker #(
    parameter int TRIG_BITS = 16
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_in_valid,
    input  wire logic        i_in_ready,
    input  wire logic [31:0] i_in_data,    // [15:0] left_ticks, [31:16] right_ticks
    input  wire logic        i_out_valid,
    input  wire logic        i_out_ready,
    input  wire logic [95:0] i_out_data,   // [31:0] pos_x, [63:32] pos_y, [95:64] heading
    input  wire logic        i_psel,
    input  wire logic        i_penable,
    input  wire logic        i_pwrite,
    input  wire logic        i_pready,
    input  wire logic [4:0]  i_paddr,
    input  wire logic [31:0] i_pwdata,
    output int               o_fail_count,
    output int               o_pending
);

    import ddo_pkg::*;

    localparam longint unsigned PI_Q30_C  = 64'hC90F_DAA2;
    localparam longint          ONE_Q30_C = 64'h4000_0000;

    typedef struct {
        logic [31:0] x;
        logic [31:0] y;
        logic [31:0] h;
    } t_pose;

    t_pose pose_q[$];

    logic [9:0]         dead_zone;
    logic [17:0]        mm_per_tick;
    logic [23:0]        turn_per_tick;
    logic [31:0]        start_x;
    logic [31:0]        start_y;
    logic [31:0]        start_hdg;
    logic signed [31:0] x_pos;
    logic signed [31:0] y_pos;
    logic [31:0]        hdg;

    initial begin
        o_fail_count = 0;
        o_pending    = 0;
    end

    function automatic longint round_half_away(input longint v, input int sh);
        longint unsigned mag;
        longint unsigned rounded;
        mag     = (v < 0) ? 64'(-v) : 64'(v);
        rounded = (mag + (64'd1 << (sh - 1))) >> sh;
        return (v < 0) ? -longint'(rounded) : longint'(rounded);
    endfunction

    function automatic logic signed [31:0] clamp32(input longint v);
        if (v > 64'sd2147483647) begin
            return 32'sh7FFF_FFFF;
        end
        if (v < -64'sd2147483648) begin
            return 32'sh8000_0000;
        end
        return 32'(v);
    endfunction

    // Taylor series in Q30 over one octant, the angle given in 2^-32 turns.
    function automatic void octant_sin_cos(input logic [31:0] a, output longint s,
                                           output longint c);
        longint unsigned prod;
        longint          x;
        longint          x2;
        longint          t;
        longint          sum;
        int              n;
        prod = 64'(a) * PI_Q30_C;
        x    = longint'(prod >> 31);
        x2   = (x * x) >>> 30;
        t    = x;
        sum  = x;
        for (n = 2; n <= 8; n += 2) begin
            t   = ((t * x2) >>> 30) / longint'(n * (n + 1));
            sum = (n & 2) ? sum - t : sum + t;
        end
        s   = sum;
        t   = ONE_Q30_C;
        sum = ONE_Q30_C;
        for (n = 1; n <= 9; n += 2) begin
            t   = ((t * x2) >>> 30) / longint'(n * (n + 1));
            sum = (n & 2) ? sum + t : sum - t;
        end
        c = sum;
    endfunction

    function automatic void heading_cos_sin(input logic [31:0] h, output longint cq,
                                            output longint sq);
        logic [31:0] frac;
        longint      s0;
        longint      c0;
        longint      s;
        longint      c;
        frac = {2'b00, h[29:0]};
        if (frac < 32'h2000_0000) begin
            octant_sin_cos(frac, s0, c0);
        end else begin
            octant_sin_cos(32'h4000_0000 - frac, c0, s0);
        end
        case (h[31:30])
            2'd0: begin c = c0;  s = s0;  end
            2'd1: begin c = -s0; s = c0;  end
            2'd2: begin c = -c0; s = -s0; end
            default: begin c = s0; s = -c0; end
        endcase
        cq = round_half_away(c, 31 - TRIG_BITS);
        sq = round_half_away(s, 31 - TRIG_BITS);
    endfunction

    task automatic advance_pose(input logic [15:0] left_raw, input logic [15:0] right_raw);
        int     l;
        int     r;
        longint travel;
        longint cq;
        longint sq;
        l = $signed(left_raw);
        r = $signed(right_raw);
        if (((l < 0) ? -l : l) < int'(dead_zone)) begin
            l = 0;
        end
        if (((r < 0) ? -r : r) < int'(dead_zone)) begin
            r = 0;
        end
        hdg    = hdg + 32'(longint'(turn_per_tick) * longint'(r - l));
        travel = longint'(mm_per_tick) * longint'(l + r);
        heading_cos_sin(hdg, cq, sq);
        x_pos = clamp32(longint'(x_pos) + round_half_away(travel * cq, TRIG_BITS + 8));
        y_pos = clamp32(longint'(y_pos) + round_half_away(travel * sq, TRIG_BITS + 8));
    endtask

    task automatic apply_write(input logic [2:0] idx, input logic [31:0] val);
        case (idx)
            REG_DEAD_ZONE:     dead_zone     = val[9:0];
            REG_MM_PER_TICK:   mm_per_tick   = val[17:0];
            REG_TURN_PER_TICK: turn_per_tick = val[23:0];
            REG_START_X:       start_x       = val;
            REG_START_Y:       start_y       = val;
            REG_START_HEADING: start_hdg     = val;
            default: ;
        endcase
        if (idx >= REG_START_X && idx <= REG_START_HEADING) begin
            x_pos = start_x;
            y_pos = start_y;
            hdg   = start_hdg;
        end
    endtask

    always @(posedge i_clk) begin
        t_pose want;
        if (!i_rst_n) begin
            dead_zone     = 10'd10;
            mm_per_tick   = 18'd18096;
            turn_per_tick = 24'd693900;
            start_x       = '0;
            start_y       = '0;
            start_hdg     = '0;
            x_pos         = '0;
            y_pos         = '0;
            hdg           = '0;
            pose_q.delete();
        end else begin
            if (i_out_valid && i_out_ready) begin
                if (pose_q.size() == 0) begin
                    $error("Pose result arrived with no request pending: %h", i_out_data);
                    o_fail_count++;
                end else begin
                    want = pose_q.pop_front();
                    if (i_out_data[31:0] !== want.x) begin
                        $error("pos_x mismatch: expected %0d, actual %0d",
                               $signed(want.x), $signed(i_out_data[31:0]));
                        o_fail_count++;
                    end
                    if (i_out_data[63:32] !== want.y) begin
                        $error("pos_y mismatch: expected %0d, actual %0d",
                               $signed(want.y), $signed(i_out_data[63:32]));
                        o_fail_count++;
                    end
                    if (i_out_data[95:64] !== want.h) begin
                        $error("heading mismatch: expected %h, actual %h",
                               want.h, i_out_data[95:64]);
                        o_fail_count++;
                    end
                end
            end
            if (i_psel && i_penable && i_pwrite && i_pready) begin
                apply_write(i_paddr[4:2], i_pwdata);
            end
            if (i_in_valid && i_in_ready) begin
                advance_pose(i_in_data[15:0], i_in_data[31:16]);
                pose_q.push_back('{x_pos, y_pos, hdg});
            end
        end
        o_pending = pose_q.size();
    end

endmodule

/* verif/tb_diff_drive_odometry.sv */
// Testbench top for the odometry block: clock, reset, stimulus, register setup and verdict.
`timescale 1ns / 1ps

module tb_diff_drive_odometry;

    import ddo_pkg::*;

    localparam int          TRIG_BITS  = 16;
    localparam int          RAND_ITEMS = 80;
    localparam logic [2:0]  REG_SPARE6 = 3'd6;
    localparam logic [2:0]  REG_SPARE7 = 3'd7;

    logic        i_clk;
    logic        i_rst_n;
    logic        s_tvalid;
    logic        s_tready;
    logic [31:0] s_tdata;    // [15:0] left_ticks, [31:16] right_ticks
    logic        m_tvalid;
    logic        m_tready;
    logic [95:0] m_tdata;    // [31:0] pos_x, [63:32] pos_y, [95:64] heading
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [4:0]  paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;

    int          fail_count;
    int          pending;
    int          results_seen = 0;
    int          burst_left;
    int          cur_dz;
    bit          long_hold_done = 1'b0;

    diff_drive_odometry #(
        .TRIG_BITS(TRIG_BITS)
    ) i_dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_axis_tvalid (s_tvalid),
        .o_s_axis_tready (s_tready),
        .i_s_axis_tdata  (s_tdata),
        .o_m_axis_tvalid (m_tvalid),
        .i_m_axis_tready (m_tready),
        .o_m_axis_tdata  (m_tdata),
        .psel            (psel),
        .penable         (penable),
        .pwrite          (pwrite),
        .paddr           (paddr),
        .pwdata          (pwdata),
        .prdata          (prdata),
        .pready          (pready)
    );

    ddo_pose_checker #(
        .TRIG_BITS(TRIG_BITS)
    ) i_checker (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (s_tvalid),
        .i_in_ready   (s_tready),
        .i_in_data    (s_tdata),
        .i_out_valid  (m_tvalid),
        .i_out_ready  (m_tready),
        .i_out_data   (m_tdata),
        .i_psel       (psel),
        .i_penable    (penable),
        .i_pwrite     (pwrite),
        .i_pready     (pready),
        .i_paddr      (paddr),
        .i_pwdata     (pwdata),
        .o_fail_count (fail_count),
        .o_pending    (pending)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    initial begin
        #5_000_000;
        $display("Simulation FAILED");
        $finish;
    end

    always @(posedge i_clk) begin
        if (m_tvalid && m_tready) begin
            results_seen <= results_seen + 1;
        end
    end

    // The result side stalls in runs of varying style, and once holds off long enough
    // that the block backs up and stops taking tick requests.
    initial begin
        int run_len;
        int style;
        m_tready = 1'b0;
        forever begin
            run_len = $urandom_range(1, 40);
            style   = $urandom_range(0, 3);
            repeat (run_len) begin
                @(negedge i_clk);
                case (style)
                    0: m_tready <= 1'b1;
                    1: m_tready <= 1'($urandom_range(0, 1));
                    2: m_tready <= ($urandom_range(0, 7) == 0);
                    default: m_tready <= ($urandom_range(0, 3) != 0);
                endcase
            end
            if (!long_hold_done && results_seen >= 120) begin
                @(negedge i_clk);
                m_tready <= 1'b0;
                repeat (400) @(negedge i_clk);
                long_hold_done = 1'b1;
            end
        end
    end

    task automatic write_reg(input logic [2:0] idx, input logic [31:0] val);
        @(negedge i_clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= val;
        @(negedge i_clk);
        penable <= 1'b1;
        @(negedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    task automatic push_ticks(input int left, input int right);
        int gap;
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 24);
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 10);
            repeat (gap) begin
                @(negedge i_clk);
                s_tvalid <= 1'b0;
            end
        end
        @(negedge i_clk);
        s_tvalid <= 1'b1;
        s_tdata  <= {16'(right), 16'(left)};
        @(posedge i_clk);
        while (!s_tready) @(posedge i_clk);
        burst_left--;
    endtask

    task automatic wait_drained();
        @(negedge i_clk);
        s_tvalid <= 1'b0;
        while (pending != 0) @(negedge i_clk);
    endtask

    function automatic logic [31:0] pick_value(input logic [31:0] lo, input logic [31:0] hi,
                                               input logic [31:0] typical);
        case ($urandom_range(0, 5))
            0: return lo;
            1: return hi;
            default: return typical;
        endcase
    endfunction

    task automatic random_setup();
        cur_dz = pick_value(0, 1023, $urandom_range(0, 60));
        write_reg(REG_DEAD_ZONE, cur_dz);
        write_reg(REG_MM_PER_TICK, pick_value(0, 262143, $urandom_range(1000, 40000)));
        write_reg(REG_TURN_PER_TICK, pick_value(0, 16777215, $urandom_range(0, 2000000)));
        write_reg(REG_START_X, pick_value(32'h8000_0000, 32'h7FFF_FFFF,
                                          ($urandom_range(0, 1) == 0) ? 32'd0 : $urandom()));
        write_reg(REG_START_Y, pick_value(32'h8000_0000, 32'h7FFF_FFFF,
                                          ($urandom_range(0, 1) == 0) ? 32'd0 : $urandom()));
        write_reg(REG_START_HEADING, pick_value(32'h0, 32'hFFFF_FFFF, $urandom()));
    endtask

    task automatic next_ticks(output int left, output int right);
        int sel;
        int base;
        sel = $urandom_range(0, 9);
        if (sel <= 5) begin
            base = $urandom_range(0, 600);
            if ($urandom_range(0, 3) == 0) begin
                base = -base;
            end
            left  = base + $urandom_range(0, 40) - 20;
            right = base + $urandom_range(0, 40) - 20;
        end else if (sel == 6) begin
            left  = $signed(16'($urandom()));
            right = $signed(16'($urandom()));
        end else if (sel == 7) begin
            left  = cur_dz + $urandom_range(0, 4) - 2;
            right = cur_dz + $urandom_range(0, 4) - 2;
            if ($urandom_range(0, 1) == 0) begin
                left = -left;
            end
            if ($urandom_range(0, 1) == 0) begin
                right = -right;
            end
        end else if (sel == 8) begin
            left  = ($urandom_range(0, 1) == 0) ? -32768 : 32767;
            right = ($urandom_range(0, 2) == 0) ? -32768 : (($urandom_range(0, 1) == 0) ? 0 : 32767);
        end else begin
            left  = $signed(16'($urandom()));
            right = -left;
        end
    endtask

    initial begin
        int left;
        int right;
        int phase;
        int k;
        i_rst_n    = 1'b0;
        s_tvalid   = 1'b0;
        s_tdata    = '0;
        psel       = 1'b0;
        penable    = 1'b0;
        pwrite     = 1'b0;
        paddr      = '0;
        pwdata     = '0;
        burst_left = 0;
        cur_dz     = 10;
        repeat (4) @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Reset settings: field extremes and the dead zone edges.
        push_ticks(0, 0);
        push_ticks(32767, 32767);
        push_ticks(-32768, -32768);
        push_ticks(32767, -32768);
        push_ticks(-32768, 32767);
        push_ticks(9, -9);
        push_ticks(10, -10);
        push_ticks(-10, 10);
        push_ticks(11, 9);
        push_ticks(-9, -11);
        push_ticks(1000, 1200);
        push_ticks(-500, 300);
        wait_drained();

        // Each request turns by one eighth of a turn, so the eight requests visit every octant.
        write_reg(REG_TURN_PER_TICK, 32'h0020_0000);
        for (k = 0; k < 8; k++) begin
            push_ticks(128, 384);
        end
        wait_drained();

        // Start near the corners so that X and Y clamp; spare addresses must do nothing.
        write_reg(REG_DEAD_ZONE, 0);
        write_reg(REG_MM_PER_TICK, 262143);
        write_reg(REG_TURN_PER_TICK, 0);
        write_reg(REG_START_X, 32'h7FFF_FF00);
        write_reg(REG_START_Y, 32'h8000_0100);
        write_reg(REG_START_HEADING, 32'hE000_0000);
        write_reg(REG_SPARE6, 32'hFFFF_FFFF);
        write_reg(REG_SPARE7, 32'h1234_5678);
        push_ticks(32767, 32767);
        push_ticks(32767, 32767);
        push_ticks(-32768, -32768);
        push_ticks(1, -1);
        wait_drained();

        // Widest dead zone and turn gain; the heading wraps past a full turn.
        cur_dz = 1023;
        write_reg(REG_DEAD_ZONE, 1023);
        write_reg(REG_MM_PER_TICK, 0);
        write_reg(REG_TURN_PER_TICK, 16777215);
        write_reg(REG_START_X, 32'h8000_0000);
        write_reg(REG_START_Y, 32'h7FFF_FFFF);
        write_reg(REG_START_HEADING, 32'hFFFF_FFF0);
        push_ticks(1022, -1022);
        push_ticks(-32768, 32767);
        push_ticks(1023, -1023);
        wait_drained();

        for (phase = 0; phase < 5; phase++) begin
            random_setup();
            for (k = 0; k < RAND_ITEMS; k++) begin
                next_ticks(left, right);
                push_ticks(left, right);
            end
            wait_drained();
        end

        repeat (60) @(posedge i_clk);
        if (fail_count == 0 && pending == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("Simulation FAILED");
        end
        $finish;
    end

endmodule

/* filelist.f */
src/ddo_pkg.sv
src/ddo_cell.sv
src/ddo_trig.sv
src/diff_drive_odometry.sv
verif/ddo_pose_checker.sv
verif/tb_diff_drive_odometry.sv
